>>> src/float_to_decimal_text_defines.svh
// Assertion macros for the float-to-text block.
// Used by the top level only; needs no other file.
`ifndef FLOAT_TO_DECIMAL_TEXT_DEFINES_SVH
`define FLOAT_TO_DECIMAL_TEXT_DEFINES_SVH
`ifndef SYNTH
`define FTDT_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define FTDT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define FTDT_ASSERT_SAME(lbl, ante, cons)
`define FTDT_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> src/ftdt_pkg.sv
// Shared types, constants and character codes of the float-to-text block.
// No dependencies.
package ftdt_pkg;

    localparam int VALUE_W    = 32;
    localparam int DIGITS_W   = 4;
    localparam int CHAR_W     = 7;
    localparam int IPART_W    = 31;
    localparam int BCD_DIGITS = 10;
    localparam int BCD_W      = 4 * BCD_DIGITS;
    localparam int MANT_W     = 24;
    localparam int SH_W       = 8;
    localparam int PROD_W     = MANT_W + 4;

    localparam int DEFAULT_MAX_FRACTION_DIGITS = 9;

    localparam logic [IPART_W-1:0] SAT_IPART    = 31'h7FFF_FFFF;
    localparam logic [MANT_W-1:0]  CARRY_LIMIT  = 24'hFF_FFFE;
    localparam logic [3:0]         DIGIT_MAX    = 4'd9;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
    localparam logic [CHAR_W-1:0] CH_POINT = 7'h2E;

    typedef struct packed {
        logic [VALUE_W-1:0]  value_bits;
        logic [DIGITS_W-1:0] digits_after_point;
    } in_item_t;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              last;
    } out_item_t;

    typedef struct packed {
        logic               neg;
        logic               zero;
        logic [IPART_W-1:0] ipart;
        logic [MANT_W-1:0]  frac_m;
        logic [SH_W-1:0]    frac_sh;
    } split_t;

    typedef struct packed {
        logic load;
        logic mul;
        logic sub;
    } frac_ctrl_t;

endpackage

>>> src/ftdt_split.sv
// Float decode: sign, integer part and exact fraction (mantissa, right shift).
// Depends on ftdt_pkg.
module ftdt_split import ftdt_pkg::*; (
    input  logic [VALUE_W-1:0] value_bits,
    output split_t             split
);

    logic [7:0]        ex;
    logic [MANT_W-1:0] m;
    logic              nan;
    logic [SH_W-1:0]   sh;
    logic [MANT_W-1:0] fm;
    logic              carry;

    always_comb begin
        ex  = value_bits[30:23];
        m   = {(ex != 8'd0), value_bits[22:0]};
        nan = (ex == 8'hFF) && (value_bits[22:0] != 23'd0);
        sh  = (ex == 8'd0) ? 8'd149 : (8'd150 - ex);
        fm  = '0;
        carry = 1'b0;

        split.zero    = (value_bits[30:0] == 31'd0);
        split.neg     = value_bits[31] && !nan;
        split.ipart   = '0;
        split.frac_m  = '0;
        split.frac_sh = SH_W'(MANT_W);

        if (ex >= 8'd158) begin
            split.ipart = SAT_IPART;
        end else if (ex >= 8'd150) begin
            split.ipart = IPART_W'(m) << 3'(ex - 8'd150);
        end else begin
            if (sh >= SH_W'(MANT_W)) begin
                fm = m;
                // only a fraction in [0.5, 1) can reach the carry limit
                carry = (sh == SH_W'(MANT_W)) && (fm >= CARRY_LIMIT);
            end else begin
                split.ipart = IPART_W'(m >> sh);
                fm = m & ((MANT_W'(1) << sh) - MANT_W'(1));
                carry = ((fm << 5'(8'd24 - sh)) >= CARRY_LIMIT);
            end
            if (carry) begin
                split.ipart = split.ipart + IPART_W'(1);
            end else begin
                split.frac_m  = fm;
                split.frac_sh = sh;
            end
        end
    end

endmodule

>>> src/ftdt_bcd.sv
// Iterative binary to BCD converter, one shift-add-3 step per cycle.
// Depends on ftdt_pkg.
module ftdt_bcd import ftdt_pkg::*; (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [IPART_W-1:0]            value,
    output logic                          done,
    output logic [BCD_DIGITS-1:0][3:0]    digits
);

    localparam int CNT_W = $clog2(IPART_W + 1);

    logic [BCD_DIGITS-1:0][3:0] bcd_reg, bcd_next, adj;
    logic [IPART_W-1:0]         bin_reg, bin_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic [BCD_W+IPART_W-1:0]   wide;

    always_comb begin
        for (int i = 0; i < BCD_DIGITS; i++) begin
            adj[i] = (bcd_reg[i] >= 4'd5) ? (bcd_reg[i] + 4'd3) : bcd_reg[i];
        end
        wide = {adj, bin_reg} << 1;
        bcd_next  = bcd_reg;
        bin_next  = bin_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            bcd_next  = '0;
            bin_next  = value;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            bcd_next = wide[BCD_W+IPART_W-1:IPART_W];
            bin_next = wide[IPART_W-1:0];
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(IPART_W - 1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        bcd_reg <= bcd_next;
        bin_reg <= bin_next;
    end

    assign done   = !busy_reg;
    assign digits = bcd_reg;

endmodule

>>> src/ftdt_frac.sv
// Fraction unit: exact single-precision multiply by ten with round to nearest even,
// then digit extraction and subtraction. Depends on ftdt_pkg.
module ftdt_frac import ftdt_pkg::*; (
    input  logic              aclk,
    input  frac_ctrl_t        ctrl,
    input  logic [MANT_W-1:0] load_m,
    input  logic [SH_W-1:0]   load_sh,
    output logic [3:0]        digit
);

    logic [MANT_W-1:0] m_reg, m_next;
    logic [SH_W-1:0]   sh_reg, sh_next;
    logic [PROD_W-1:0] prod, lowmask, half, rem;
    logic [2:0]        k, kk;
    logic [MANT_W:0]   kept, rnd;
    logic              up;
    logic [MANT_W-1:0] mul_m, sub_m;
    logic              big;
    logic [3:0]        int_val;

    always_comb begin
        // multiply by ten and round back to 24 significant bits
        prod = PROD_W'({m_reg, 3'b000}) + PROD_W'({m_reg, 1'b0});
        priority if (prod[27]) k = 3'd4;
        else if (prod[26])     k = 3'd3;
        else if (prod[25])     k = 3'd2;
        else if (prod[24])     k = 3'd1;
        else                   k = 3'd0;
        kept    = (MANT_W+1)'(prod >> k);
        lowmask = (PROD_W'(1) << k) - PROD_W'(1);
        half    = (k == 3'd0) ? '0 : (PROD_W'(1) << (k - 3'd1));
        rem     = prod & lowmask;
        up      = (rem > half) || ((rem == half) && (k != 3'd0) && kept[0]);
        rnd     = kept + (MANT_W+1)'(up);
        if (rnd[MANT_W]) begin
            mul_m = rnd[MANT_W:1];
            kk    = k + 3'd1;
        end else begin
            mul_m = rnd[MANT_W-1:0];
            kk    = k;
        end

        // integer digit of the product, saturated at nine
        big     = (sh_reg >= SH_W'(MANT_W));
        int_val = big ? 4'd0 : 4'(m_reg >> sh_reg);
        digit   = (int_val >= DIGIT_MAX) ? DIGIT_MAX : int_val;
        sub_m   = big ? m_reg : (m_reg - (MANT_W'(digit) << sh_reg[4:0]));

        m_next  = m_reg;
        sh_next = sh_reg;
        unique if (ctrl.load) begin
            m_next  = load_m;
            sh_next = load_sh;
        end else if (ctrl.mul) begin
            m_next  = mul_m;
            sh_next = sh_reg - SH_W'(kk);
        end else if (ctrl.sub) begin
            m_next  = sub_m;
        end else begin
            m_next  = m_reg;
        end
    end

    always_ff @(posedge aclk) begin
        m_reg  <= m_next;
        sh_reg <= sh_next;
    end

endmodule

>>> src/float_to_decimal_text.sv
// Single-precision float to fixed-notation ASCII text, one character per output transfer.
// Sequence: accept and a decode state, then the sign leaves while the binary-to-BCD
// iteration runs; the integer digits are then scanned from the top BCD position,
// skipping leading zeros but always emitting the units digit.
// One value at a time; all ten BCD positions are scanned, then a point and, per fraction
// digit, a multiply state and a digit state when any are asked for.
// Reset: aresetn synchronous, active low; clears the sequencer and the output valid.
`include "float_to_decimal_text_defines.svh"

module float_to_decimal_text import ftdt_pkg::*; #(
    parameter int MAX_FRACTION_DIGITS = DEFAULT_MAX_FRACTION_DIGITS
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    localparam int NDIG_W = $clog2(MAX_FRACTION_DIGITS + 1);
    localparam int IDX_W  = $clog2(BCD_DIGITS);

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_DECODE = 8'b0000_0010,
        ST_SIGN   = 8'b0000_0100,
        ST_CONV   = 8'b0000_1000,
        ST_INT    = 8'b0001_0000,
        ST_POINT  = 8'b0010_0000,
        ST_FMUL   = 8'b0100_0000,
        ST_FDIG   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [VALUE_W-1:0] bits_reg, bits_next;
    logic [NDIG_W-1:0]  ndig_reg, ndig_next;
    logic               neg_reg, neg_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic               lead_reg, lead_next;
    logic               m_valid_reg, m_valid_next;
    out_item_t          m_data_reg, m_data_next;

    split_t                     split;
    logic                       bcd_start, bcd_done;
    logic [BCD_DIGITS-1:0][3:0] bcd_digits;
    frac_ctrl_t                 fctrl;
    logic [3:0]                 frac_digit;

    logic              emit_req, can_emit, fire;
    out_item_t         emit_item;
    logic [3:0]        int_digit;

    ftdt_split u_split (
        .value_bits (bits_reg),
        .split      (split)
    );

    ftdt_bcd u_bcd (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (bcd_start),
        .value   (split.ipart),
        .done    (bcd_done),
        .digits  (bcd_digits)
    );

    ftdt_frac u_frac (
        .aclk    (aclk),
        .ctrl    (fctrl),
        .load_m  (split.frac_m),
        .load_sh (split.frac_sh),
        .digit   (frac_digit)
    );

    // Output register: take a new character when empty or when the one held leaves.
    assign can_emit  = !m_valid_reg || m_ready;
    assign fire      = emit_req && can_emit;
    assign int_digit = bcd_digits[idx_reg];
    assign s_ready   = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        bits_next  = bits_reg;
        ndig_next  = ndig_reg;
        neg_next   = neg_reg;
        idx_next   = idx_reg;
        lead_next  = lead_reg;
        bcd_start  = 1'b0;
        fctrl      = '0;
        emit_req   = 1'b0;
        emit_item  = '{char_code: CH_ZERO, last: 1'b0};

        unique case (state_reg)
            ST_IDLE: begin
                // latch the request and clamp the digit count
                if (s_valid) begin
                    bits_next = s_data.value_bits;
                    if (s_data.digits_after_point > DIGITS_W'(MAX_FRACTION_DIGITS)) begin
                        ndig_next = NDIG_W'(MAX_FRACTION_DIGITS);
                    end else begin
                        ndig_next = NDIG_W'(s_data.digits_after_point);
                    end
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                // start the integer conversion and load the fraction unit
                bcd_start  = 1'b1;
                fctrl.load = 1'b1;
                neg_next   = split.neg;
                if (split.zero) begin
                    ndig_next = '0;
                end
                state_next = ST_SIGN;
            end
            ST_SIGN: begin
                if (neg_reg) begin
                    emit_req  = 1'b1;
                    emit_item = '{char_code: CH_MINUS, last: 1'b0};
                    if (fire) begin
                        state_next = ST_CONV;
                    end
                end else begin
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                if (bcd_done) begin
                    idx_next   = IDX_W'(BCD_DIGITS - 1);
                    lead_next  = 1'b1;
                    state_next = ST_INT;
                end
            end
            ST_INT: begin
                // drop leading zeros, but always emit the units digit
                if (lead_reg && (int_digit == 4'd0) && (idx_reg != '0)) begin
                    idx_next = idx_reg - IDX_W'(1);
                end else begin
                    emit_req  = 1'b1;
                    emit_item = '{char_code: CH_ZERO + CHAR_W'(int_digit),
                                  last: (idx_reg == '0) && (ndig_reg == '0)};
                    if (fire) begin
                        lead_next = 1'b0;
                        if (idx_reg == '0) begin
                            state_next = (ndig_reg == '0) ? ST_IDLE : ST_POINT;
                        end else begin
                            idx_next = idx_reg - IDX_W'(1);
                        end
                    end
                end
            end
            ST_POINT: begin
                emit_req  = 1'b1;
                emit_item = '{char_code: CH_POINT, last: 1'b0};
                if (fire) begin
                    state_next = ST_FMUL;
                end
            end
            ST_FMUL: begin
                fctrl.mul  = 1'b1;
                state_next = ST_FDIG;
            end
            ST_FDIG: begin
                emit_req  = 1'b1;
                emit_item = '{char_code: CH_ZERO + CHAR_W'(frac_digit),
                              last: (ndig_reg == NDIG_W'(1))};
                if (fire) begin
                    fctrl.sub  = 1'b1;
                    ndig_next  = ndig_reg - NDIG_W'(1);
                    state_next = (ndig_reg == NDIG_W'(1)) ? ST_IDLE : ST_FMUL;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (fire) begin
            m_valid_next = 1'b1;
            m_data_next  = emit_item;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        bits_reg   <= bits_next;
        ndig_reg   <= ndig_next;
        neg_reg    <= neg_next;
        idx_reg    <= idx_next;
        lead_reg   <= lead_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // An accepted request holds off the next one until its text is sequenced.
    `FTDT_ASSERT_NEXT(a_accept_busy, s_valid && s_ready, !s_ready)
    // Integer digits are read only after the BCD iteration has finished.
    `FTDT_ASSERT_SAME(a_int_after_conv, state_reg == ST_INT, bcd_done)
    // A fraction digit step never runs with no digits left.
    `FTDT_ASSERT_SAME(a_fdig_count, state_reg == ST_FDIG || state_reg == ST_FMUL, ndig_reg != '0)

endmodule

>>> dv/tb.sv
// Self-checking bench for float_to_decimal_text: drives float bit patterns and digit
// counts, and compares each output character with typed texts or a bit-exact integer model.
// Depends on ftdt_pkg and the float_to_decimal_text RTL.
module tb;
    import ftdt_pkg::*;

    localparam int MAX_DIGITS = 9;
    localparam int FRAC_BITS  = 149;  // fixed point: one unit is the smallest subnormal
    localparam logic [159:0] CARRY_FIX = (160'd1 << FRAC_BITS) - (160'd1 << 126);
    localparam logic [31:0]  SAT_VALUE = 32'd2147483647;

    logic      aclk = 0;
    logic      aresetn = 0;
    logic      s_valid = 0;
    logic      s_ready;
    in_item_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 0;
    out_item_t m_data;

    out_item_t expected_chars[$];
    int        error_count = 0;
    int        chars_checked = 0;
    int        values_sent = 0;
    int        idle_pct = 0;
    int        stall_pct = 0;
    int        hold_left = 0;
    bit        hold_req = 0;

    typedef struct {
        logic [31:0] value;
        logic [3:0]  ndig;
        string       text;   // empty: take the expectation from predict_text
    } row_t;

    row_t dir_rows [21] = '{
        '{32'h0000_0000, 4'd5,  "0"},
        '{32'h8000_0000, 4'd0,  "-0"},
        '{32'h3F80_0000, 4'd0,  "1"},
        '{32'h3FC0_0000, 4'd1,  "1.5"},
        '{32'hC010_0000, 4'd2,  "-2.25"},
        '{32'h3F00_0000, 4'd15, "0.500000000"},
        '{32'h7F80_0000, 4'd3,  "2147483647.000"},
        '{32'hFF80_0000, 4'd3,  "-2147483647.000"},
        '{32'h7FC0_0000, 4'd2,  "2147483647.00"},
        '{32'hFFC0_0000, 4'd1,  "2147483647.0"},
        '{32'hFFFF_FFFF, 4'd15, "2147483647.000000000"},
        '{32'h4F00_0000, 4'd0,  "2147483647"},
        '{32'h4EFF_FFFF, 4'd0,  "2147483520"},
        '{32'h3F7F_FFFF, 4'd2,  "1.00"},
        '{32'h3F7F_FFFE, 4'd1,  "1.0"},
        '{32'h0000_0001, 4'd9,  "0.000000000"},
        '{32'h8000_0001, 4'd4,  "-0.0000"},
        '{32'h3F7F_FFFD, 4'd3,  ""},
        '{32'h3DCC_CCCD, 4'd9,  ""},
        '{32'h807F_FFFF, 4'd9,  ""},
        '{32'h7F7F_FFFF, 4'd9,  ""}
    };

    float_to_decimal_text DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Queue a finished text; the final character carries last.
    function automatic void queue_text(logic [6:0] chars[$]);
        out_item_t o;
        foreach (chars[i]) begin
            o.char_code = chars[i];
            o.last      = (i == chars.size() - 1);
            expected_chars.push_back(o);
        end
    endfunction

    // Work out the text of one request. Values are held as exact fixed-point integers
    // with 149 fraction bits; each multiply by ten is rounded to 24 significant bits,
    // nearest even, just as a single-precision multiply would.
    function automatic void predict_text(in_item_t it);
        logic [31:0]  b;
        int           nd;
        logic [7:0]   ex;
        logic [23:0]  man;
        logic [191:0] wide;
        logic [159:0] fr;
        logic [159:0] prod;
        logic [159:0] keep;
        logic [159:0] rem;
        logic [159:0] half;
        logic [31:0]  ip;
        logic [6:0]   chars[$];
        logic [6:0]   rev[$];
        int           p;
        int           sh;
        int           d;
        b  = it.value_bits;
        nd = (it.digits_after_point > MAX_DIGITS) ? MAX_DIGITS : it.digits_after_point;
        if (b[30:0] == 0) begin
            if (b[31]) chars.push_back(CH_MINUS);
            chars.push_back(CH_ZERO);
            queue_text(chars);
            return;
        end
        ex = b[30:23];
        // NaN shows no sign; infinity keeps it
        if (b[31] && !(ex == 8'hFF && b[22:0] != 0)) chars.push_back(CH_MINUS);
        if (ex >= 8'd158) begin
            ip = SAT_VALUE;
            fr = '0;
        end else begin
            man  = (ex == 0) ? {1'b0, b[22:0]} : {1'b1, b[22:0]};
            wide = (ex == 0) ? 192'(man) : (192'(man) << (ex - 1));
            ip   = 32'(wide >> FRAC_BITS);
            fr   = 160'(wide[FRAC_BITS-1:0]);
            if (fr >= CARRY_FIX) begin
                ip = ip + 1;
                fr = '0;
            end
        end
        do begin
            rev.push_front(CH_ZERO + 7'(ip % 10));
            ip = ip / 10;
        end while (ip != 0);
        foreach (rev[i]) chars.push_back(rev[i]);
        if (nd > 0) begin
            chars.push_back(CH_POINT);
            for (int k = 0; k < nd; k++) begin
                prod = fr * 10;
                p = 0;
                for (int j = 0; j < 160; j++) if (prod[j]) p = j;
                if (p > 23) begin
                    sh   = p - 23;
                    keep = prod >> sh;
                    rem  = prod & ((160'd1 << sh) - 1);
                    half = 160'd1 << (sh - 1);
                    if (rem > half || (rem == half && keep[0])) keep = keep + 1;
                    prod = keep << sh;
                end
                d = ((prod >> FRAC_BITS) >= 9) ? 9 : int'(prod >> FRAC_BITS);
                fr = prod - (160'(d) << FRAC_BITS);
                chars.push_back(CH_ZERO + 7'(d));
            end
        end
        queue_text(chars);
    endfunction

    task automatic report_mismatch(string what, logic [6:0] got, logic [6:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Offer one request, with a random idle gap first, and hold it until accepted.
    task automatic send_request(in_item_t it);
        int gap;
        if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            gap = $urandom_range(1, 6);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        values_sent++;
    endtask

    function automatic in_item_t random_request();
        in_item_t it;
        int       kind;
        kind = $urandom_range(99);
        it.value_bits = $urandom;
        // mostly sensible magnitudes with random content; the rest raw bit noise
        if (kind < 45)      it.value_bits[30:23] = 8'($urandom_range(112, 157));
        else if (kind < 60) it.value_bits[30:23] = 8'($urandom_range(120, 128));
        else if (kind < 65) it.value_bits[30:23] = 8'($urandom_range(0, 1));
        else if (kind < 70) it.value_bits[30:23] = 8'($urandom_range(156, 255));
        else if (kind < 75) it.value_bits[30:0]  = '0;
        it.digits_after_point = 4'($urandom_range(15));
        return it;
    endfunction

    // Receiver: random stalls, or a long hold-off when one is requested.
    always @(posedge aclk) begin
        if (hold_req) begin
            hold_left = 400;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Checker: every accepted character against the oldest expectation.
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_chars.size() == 0) begin
                report_mismatch("unexpected char", m_data.char_code, '0);
            end else begin
                want = expected_chars.pop_front();
                chars_checked++;
                if (m_data.char_code !== want.char_code)
                    report_mismatch("char_code", m_data.char_code, want.char_code);
                if (m_data.last !== want.last)
                    report_mismatch("last", 7'(m_data.last), 7'(want.last));
            end
        end
    end

    initial begin
        #4_000_000;
        $display("FAIL float_to_decimal_text");
        $finish;
    end

    initial begin
        in_item_t   it;
        logic [6:0] typed[$];
        int         idle_set  [4] = '{0, 65, 0, 26};
        int         stall_set [4] = '{0, 0, 65, 26};
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table, no idling
        foreach (dir_rows[r]) begin
            it.value_bits         = dir_rows[r].value;
            it.digits_after_point = dir_rows[r].ndig;
            send_request(it);
            if (dir_rows[r].text.len() == 0) begin
                predict_text(it);
            end else begin
                typed.delete();
                for (int c = 0; c < dir_rows[r].text.len(); c++)
                    typed.push_back(7'(dir_rows[r].text[c]));
                queue_text(typed);
            end
        end

        // random phases, each with its own idle and stall mix
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct  = idle_set[ph];
            stall_pct = stall_set[ph];
            for (int n = 0; n < 75; n++) begin
                // stall the output for a long stretch while requests keep coming
                if (ph == 2 && n == 10) hold_req = 1;
                // pause the sender until the output has drained
                if (ph == 1 && n == 40) begin
                    s_valid <= 1'b0;
                    @(posedge aclk);
                    while (expected_chars.size() != 0) @(posedge aclk);
                end
                it = random_request();
                send_request(it);
                predict_text(it);
            end
        end
        s_valid <= 1'b0;

        while (expected_chars.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        $display("covered %0d values, %0d characters checked, across zero, NaN, infinity,",
                 values_sent, chars_checked);
        $display("saturation, carry, subnormals and four idle/stall mixes");
        if (error_count == 0) begin
            $display("PASS float_to_decimal_text");
        end else begin
            $display("FAIL float_to_decimal_text");
        end
        $finish;
    end
endmodule
